[rtl/core/tpzb_pkg.sv]
// ----------------------------------------------------------------------------
// tpzb_pkg
// Shared constants, register indexes and table functions for the torus
// point plotter.
// ----------------------------------------------------------------------------
package tpzb_pkg;

    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 22;
    localparam int PHASE_BITS_DEF = 10;

    // fixed field widths
    localparam int PHASE_W = 10;
    localparam int CELL_W  = 11;
    localparam int GLYPH_W = 8;
    localparam int IDX_W   = 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROT_A = 1'd0;
    localparam logic [IDX_W-1:0] REG_ROT_B = 1'd1;

    localparam logic [3:0] SHADE_EMPTY = 4'd12;
    localparam logic [3:0] SHADE_MAX   = 4'd11;
    localparam int         ONE_Q14     = 16384;

    localparam logic [GLYPH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [GLYPH_W-1:0] CH_NEWLINE = 8'h0A;

    // Q14 quarter-wave sine, r in [0, 2^(pb-2)]; evaluated at elaboration only
    function automatic logic [14:0] quarter_sine(input int unsigned r, input int unsigned pb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        x  = 64'(r) << (32 - pb);
        x2 = (x * x) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995 - ((x2 * p) >> 30);
        p  = 64'd85569306 - ((x2 * p) >> 30);
        p  = 64'd693598668 - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        s  = (s + 64'd32768) >> 16;
        if (s > 64'(ONE_Q14))
        begin
            s = 64'(ONE_Q14);
        end
        return s[14:0];
    endfunction

    // ".,-~:;=!*#$@"
    function automatic logic [GLYPH_W-1:0] shade_glyph(input logic [3:0] s);
        logic [GLYPH_W-1:0] ch;
        case (s)
            4'd0:    ch = 8'h2E;
            4'd1:    ch = 8'h2C;
            4'd2:    ch = 8'h2D;
            4'd3:    ch = 8'h7E;
            4'd4:    ch = 8'h3A;
            4'd5:    ch = 8'h3B;
            4'd6:    ch = 8'h3D;
            4'd7:    ch = 8'h21;
            4'd8:    ch = 8'h2A;
            4'd9:    ch = 8'h23;
            4'd10:   ch = 8'h24;
            4'd11:   ch = 8'h40;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

[rtl/core/torus_point_zbuffer_plotter.sv]
// ----------------------------------------------------------------------------
// torus_point_zbuffer_plotter
// Rotates torus surface samples, projects them and keeps the nearest one per
// screen cell in a depth/shade memory; read beats return and clear a cell.
// ----------------------------------------------------------------------------
// One item at a time. After reset the block sweeps all COLUMNS*ROWS cells
// of the cell memory (1760 by default), one cell per cycle, with s_tready
// low. A plot beat then runs 8 sine table reads plus 16 products on one
// shared 20x20 multiplier, a one-bit-per-cycle divider for the inverse
// depth, the projection steps and a read-modify-write of the cell. A read
// beat reads the memory as it is taken, then puts the glyph out and clears
// the cell, and waits only while m_tdata holds an untaken result.
// Configuration writes are always taken.
module torus_point_zbuffer_plotter #(
    parameter int COLUMNS    = tpzb_pkg::COLUMNS_DEF,
    parameter int ROWS       = tpzb_pkg::ROWS_DEF,
    parameter int PHASE_BITS = tpzb_pkg::PHASE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tpzb_pkg::IDX_W-1:0] cfg_index,
    input  logic [tpzb_pkg::PHASE_W-1:0] cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [9:0] theta_phase, [19:10] phi_phase, [30:20] cell_index
    input  logic [0:0]  s_tuser,   // [0] action: 0 plot, 1 read and clear
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] glyph, [18:8] read_cell
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int PB      = PHASE_BITS;
    localparam int QUARTER = 1 << (PB - 2);
    localparam int VAL_W   = 20;
    localparam int DEN_W   = 18;
    localparam int Q_W     = 17;
    localparam int XP_W    = 37;
    localparam int XS_W    = 44;
    localparam int POS_W   = 14;
    localparam logic [4:0] STEP_LAST = 5'd23;
    localparam logic [4:0] PROJ_LAST = 5'd4;
    localparam logic signed [XS_W-1:0] X_CTR = XS_W'(COLUMNS / 2) <<< 30;
    localparam logic signed [XS_W-1:0] Y_CTR = XS_W'(ROWS / 2 + 1) <<< 30;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CALC  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_PROJ  = 7'b0010000,
        ST_RMW   = 7'b0100000,
        ST_RD    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // ---------------- registers ----------------
    logic [PB-1:0] rot_a_reg, rot_b_reg, ti_reg, pj_reg;
    logic [4:0]    step_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [tpzb_pkg::CELL_W-1:0] k_reg;
    logic          ok_reg;
    logic signed [VAL_W-1:0] c_reg, l_reg, f_reg, d_reg, e_reg, g_reg, n_reg, m_reg;
    logic signed [VAL_W-1:0] ch_reg, den_reg, p2_reg, t_reg, p4_reg, lh_reg;
    logic signed [VAL_W-1:0] u_reg, v_reg, cd_reg, tmp_reg, w_reg;
    logic [DEN_W-1:0] dsr_reg, rem_reg;
    logic [Q_W-1:0]   dvd_reg, q_reg;
    logic [15:0]      dq_reg;
    logic signed [XP_W-1:0] xprod_reg, yprod_reg;
    logic [POS_W-1:0] x_reg, y_reg;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    // ---------------- cell memory: {depth[15:0], shade[3:0]} ----------------
    logic [19:0] mem [CELLS];
    logic [19:0] mem_rdata;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [19:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // ---------------- sine table ----------------
    logic [14:0] qtab [QUARTER+1];
    for (genvar gi = 0; gi <= QUARTER; gi++)
    begin : g_qtab
        assign qtab[gi] = tpzb_pkg::quarter_sine(gi, PB);
    end

    logic [PB-1:0] ph_base, ph_sel;
    logic [1:0]    ph_q;
    logic [PB-2:0] ph_idx;
    logic [14:0]   ph_mag;
    logic signed [VAL_W-1:0] sin_val;

    always_comb
    begin
        case (step_reg[2:1])
            2'd0:    ph_base = ti_reg;
            2'd1:    ph_base = pj_reg;
            2'd2:    ph_base = rot_a_reg;
            default: ph_base = rot_b_reg;
        endcase
        // odd fetch steps read the cosine
        ph_sel = step_reg[0] ? ph_base + PB'(QUARTER) : ph_base;
        ph_q   = ph_sel[PB-1:PB-2];
        ph_idx = ph_q[0] ? (PB-1)'(QUARTER) - {1'b0, ph_sel[PB-3:0]}
                         : {1'b0, ph_sel[PB-3:0]};
        ph_mag = qtab[ph_idx];
        sin_val = ph_q[1] ? -VAL_W'(ph_mag) : VAL_W'(ph_mag);
    end

    // ---------------- shared Q14 multiplier ----------------
    logic signed [VAL_W-1:0] h_val, op_a, op_b, mq;
    logic signed [2*VAL_W-1:0] prod, prod_rnd;

    assign h_val = d_reg + VAL_W'(2 * tpzb_pkg::ONE_Q14);

    always_comb
    begin
        case (step_reg)
            5'd8:    begin op_a = c_reg;   op_b = h_val; end
            5'd9:    begin op_a = ch_reg;  op_b = e_reg; end
            5'd10:   begin op_a = f_reg;   op_b = g_reg; end
            5'd11:   begin op_a = ch_reg;  op_b = g_reg; end
            5'd12:   begin op_a = f_reg;   op_b = e_reg; end
            5'd13:   begin op_a = l_reg;   op_b = h_val; end
            5'd14:   begin op_a = lh_reg;  op_b = m_reg; end
            5'd15:   begin op_a = t_reg;   op_b = n_reg; end
            5'd16:   begin op_a = lh_reg;  op_b = n_reg; end
            5'd17:   begin op_a = t_reg;   op_b = m_reg; end
            5'd18:   begin op_a = c_reg;   op_b = d_reg; end
            5'd19:   begin op_a = cd_reg;  op_b = g_reg; end
            5'd20:   begin op_a = tmp_reg; op_b = m_reg; end
            5'd21:   begin op_a = cd_reg;  op_b = e_reg; end
            5'd22:   begin op_a = l_reg;   op_b = d_reg; end
            5'd23:   begin op_a = tmp_reg; op_b = n_reg; end
            default: begin op_a = c_reg;   op_b = h_val; end
        endcase
        prod     = op_a * op_b;
        prod_rnd = (prod + (2*VAL_W)'(8192)) >>> 14;
        mq       = prod_rnd[VAL_W-1:0];
    end

    // ---------------- divider setup and step ----------------
    logic [DEN_W-1:0] den_clamp;
    logic [30:0]      dividend;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        den_clamp = (den_reg < VAL_W'(tpzb_pkg::ONE_Q14)) ? DEN_W'(tpzb_pkg::ONE_Q14)
                                                         : den_reg[DEN_W-1:0];
        dividend  = 31'(1 << 30) + 31'(den_clamp >> 1);
        trial     = {rem_reg, dvd_reg[Q_W-1]};
    end

    // ---------------- projection ----------------
    logic signed [XS_W-1:0] xs, ys;
    logic x_ok, y_ok;
    logic [ADDR_W-1:0] proj_addr;

    always_comb
    begin
        xs = X_CTR + (XS_W'(xprod_reg) <<< 5) - (XS_W'(xprod_reg) <<< 1);
        ys = Y_CTR + (XS_W'(yprod_reg) <<< 4) - XS_W'(yprod_reg);
        // floor is enough: any negative coordinate is off screen anyway
        x_ok = !x_reg[POS_W-1] && (x_reg != '0) && (x_reg < POS_W'(COLUMNS));
        y_ok = !y_reg[POS_W-1] && (y_reg != '0) && (y_reg < POS_W'(ROWS));
        proj_addr = ADDR_W'(32'(x_reg) + 32'(y_reg) * COLUMNS);
    end

    // shade index, clamped to [0, 11]
    logic signed [VAL_W-1:0] w_sh;
    logic [3:0] nn;

    always_comb
    begin
        w_sh = w_reg >>> 11;
        if (w_sh[VAL_W-1])
        begin
            nn = 4'd0;
        end
        else if (w_sh > VAL_W'(tpzb_pkg::SHADE_MAX))
        begin
            nn = tpzb_pkg::SHADE_MAX;
        end
        else
        begin
            nn = w_sh[3:0];
        end
    end

    // ---------------- read path ----------------
    logic in_range, col0, out_free;
    logic [tpzb_pkg::GLYPH_W-1:0] glyph;

    always_comb
    begin
        in_range = 32'(k_reg) < CELLS;
        col0 = 1'b0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (32'(k_reg) == r * COLUMNS)
            begin
                col0 = 1'b1;
            end
        end
        if (!in_range)
        begin
            glyph = tpzb_pkg::CH_SPACE;
        end
        else if (col0)
        begin
            glyph = tpzb_pkg::CH_NEWLINE;
        end
        else
        begin
            glyph = tpzb_pkg::shade_glyph(mem_rdata[3:0]);
        end
        out_free = !m_valid_reg || m_tready;
    end

    // ---------------- memory port control ----------------
    logic rmw_hit;
    assign rmw_hit = ok_reg && (dq_reg > mem_rdata[19:4]);

    always_comb
    begin
        // last projection step reads the target cell for the update cycle
        if (state_reg == ST_IDLE)
        begin
            mem_raddr = ADDR_W'(s_tdata[30:20]);
        end
        else if (state_reg == ST_PROJ)
        begin
            mem_raddr = proj_addr;
        end
        else
        begin
            mem_raddr = addr_reg;
        end
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = {16'd0, tpzb_pkg::SHADE_EMPTY};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_RMW:
            begin
                mem_we    = rmw_hit;
                mem_wdata = {dq_reg, nn};
            end
            ST_RD:
            begin
                mem_we = out_free && in_range;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    logic s_fire;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (32'(clr_reg) == CELLS - 1) state_next = ST_IDLE;
            ST_IDLE:  if (s_fire) state_next = s_tuser[0] ? ST_RD : ST_CALC;
            ST_CALC:  if (step_reg == STEP_LAST) state_next = ST_DIV;
            ST_DIV:   if (step_reg == 5'(Q_W - 1)) state_next = ST_PROJ;
            ST_PROJ:  if (step_reg == PROJ_LAST) state_next = ST_RMW;
            ST_RMW:   state_next = ST_IDLE;
            ST_RD:    if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            clr_reg     <= '0;
            rot_a_reg   <= '0;
            rot_b_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tpzb_pkg::REG_ROT_A: rot_a_reg <= PB'(cfg_data);
                    tpzb_pkg::REG_ROT_B: rot_b_reg <= PB'(cfg_data);
                    default:             rot_a_reg <= rot_a_reg;
                endcase
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_next != state_reg)
            begin
                step_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == ST_RD && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            ti_reg   <= PB'(s_tdata[9:0]);
            pj_reg   <= PB'(s_tdata[19:10]);
            k_reg    <= s_tdata[30:20];
            addr_reg <= ADDR_W'(s_tdata[30:20]);
        end
        if (state_reg == ST_RD && out_free)
        begin
            m_data_reg <= {5'd0, k_reg, glyph};
        end
        if (state_reg == ST_CALC)
        begin
            case (step_reg)
                5'd0:  c_reg <= sin_val;
                5'd1:  l_reg <= sin_val;
                5'd2:  f_reg <= sin_val;
                5'd3:  d_reg <= sin_val;
                5'd4:  e_reg <= sin_val;
                5'd5:  g_reg <= sin_val;
                5'd6:  n_reg <= sin_val;
                5'd7:  m_reg <= sin_val;
                5'd8:  ch_reg <= mq;
                5'd9:  den_reg <= mq + VAL_W'(5 * tpzb_pkg::ONE_Q14);
                5'd10:
                begin
                    den_reg <= den_reg + mq;
                    p2_reg  <= mq;
                end
                5'd11: t_reg <= mq;
                5'd12:
                begin
                    t_reg  <= t_reg - mq;
                    p4_reg <= mq;
                end
                5'd13: lh_reg <= mq;
                5'd14: u_reg <= mq;
                5'd15: u_reg <= u_reg - mq;
                5'd16: v_reg <= mq;
                5'd17: v_reg <= v_reg + mq;
                5'd18: cd_reg <= mq;
                5'd19: tmp_reg <= p4_reg - mq;
                5'd20: w_reg <= mq - p2_reg;
                5'd21: w_reg <= w_reg - mq;
                5'd22: tmp_reg <= mq;
                5'd23:
                begin
                    w_reg   <= w_reg - mq;
                    // divider setup: quotient fits 17 bits since den >= 1.0
                    dsr_reg <= den_clamp;
                    rem_reg <= DEN_W'(dividend[30:Q_W]);
                    dvd_reg <= dividend[Q_W-1:0];
                    q_reg   <= '0;
                end
                default: tmp_reg <= tmp_reg;
            endcase
        end
        if (state_reg == ST_DIV)
        begin
            dvd_reg <= dvd_reg << 1;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= DEN_W'(trial - {1'b0, dsr_reg});
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_PROJ)
        begin
            case (step_reg)
                5'd0:
                begin
                    dq_reg    <= q_reg[Q_W-1] ? 16'hFFFF : q_reg[15:0];
                end
                5'd1: xprod_reg <= $signed({1'b0, dq_reg}) * u_reg;
                5'd2:
                begin
                    yprod_reg <= $signed({1'b0, dq_reg}) * v_reg;
                    x_reg     <= xs[30+POS_W-1:30];
                end
                5'd3: y_reg <= ys[30+POS_W-1:30];
                5'd4:
                begin
                    ok_reg   <= x_ok && y_ok;
                    addr_reg <= proj_addr;
                end
                default: ok_reg <= ok_reg;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    a_mem_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_RMW || state_reg == ST_RD))
        else $error("cell memory written outside clear, update or read");

    a_read_goes_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tuser[0]) |=> (state_reg == ST_RD))
        else $error("read beat did not enter read state");

    a_out_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_RD))
        else $error("result raised outside read state");

    a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_RMW) |-> (mem_wdata[3:0] <= tpzb_pkg::SHADE_MAX))
        else $error("plotted shade out of range");

endmodule
